/* rtl/core/tnis_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_pkg
// Shared types and constants of the streaming top-n index select block.
// ----------------------------------------------------------------------------
package tnis_pkg;

   // Number of kept entries, one cell each
   localparam int MAX_KEEP   = 8;
   // Elements per vector before the arrival index wraps
   localparam int VECTOR_LEN = 4096;

   localparam int SCORE_W    = 32;
   localparam int INDEX_W    = 12;
   localparam int RANK_W     = 3;
   localparam int NKEEP_W    = 4;
   // Counter wide enough to hold MAX_KEEP itself
   localparam int CNT_W      = $clog2(MAX_KEEP + 1);
   // Width used to compare the register value against MAX_KEEP
   localparam int LIM_W      = (CNT_W > NKEEP_W) ? CNT_W : NKEEP_W;

   // Result word: rank, element index, element score, zero pad to bytes
   localparam int RSP_BITS   = RANK_W + INDEX_W + SCORE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_W = ((SCORE_W + 7) / 8) * 8;

   // One kept entry of the list
   typedef struct packed {
      logic                      valid;
      logic signed [SCORE_W-1:0] score;
      logic [INDEX_W-1:0]        index;
   } entry_type;

endpackage

/* rtl/core/tnis_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_cell
// One slot of the sorted list: keeps an entry, takes the new element or the
// entry of its upper neighbor when an element is inserted.
// ----------------------------------------------------------------------------
module tnis_cell
   import tnis_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      insert_i,     // element transfer
   input  logic                      clear_i,      // last element of vector
   input  logic signed [SCORE_W-1:0] new_score_i,
   input  logic [INDEX_W-1:0]        new_index_i,
   input  logic                      prev_take_i,  // upper neighbor takes new
   input  entry_type                 prev_entry_i,
   output logic                      take_o,
   output entry_type                 entry_o,
   output entry_type                 entry_in_o    // contents after insertion
);

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;

   // New element wins this slot when the slot is empty or strictly lower
   assign take_o = !entry_ff.valid || (new_score_i > entry_ff.score);

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.score = new_score_i;
      new_entry.index = new_index_i;
      entry_in = entry_ff;
      if (insert_i) begin
         if (prev_take_i) begin
            entry_in = prev_entry_i;
         end else if (take_o) begin
            entry_in = new_entry;
         end
      end
   end

   // Hold the entry; drop it at reset and at the end of a vector
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else if (clear_i) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.score <= entry_in.score;
      entry_ff.index <= entry_in.index;
   end

   assign entry_o    = entry_ff;
   assign entry_in_o = entry_in;

endmodule

/* rtl/core/tnis_drain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnis_drain
// Result buffer: captures the finished list and shifts it out best first.
// ----------------------------------------------------------------------------
module tnis_drain
   import tnis_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_i,
   input  entry_type                 load_entries_i [MAX_KEEP],
   input  logic [CNT_W-1:0]          load_count_i,
   output logic                      busy_o,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RANK_W-1:0]         rsp_rank_o,
   output logic [INDEX_W-1:0]        rsp_index_o,
   output logic signed [SCORE_W-1:0] rsp_score_o,
   output logic                      rsp_tlast
);

   entry_type          slot_ff [MAX_KEEP];
   entry_type          slot_in [MAX_KEEP];
   logic [CNT_W-1:0]   remain_ff;
   logic [CNT_W-1:0]   remain_in;
   logic [RANK_W-1:0]  rank_ff;
   logic [RANK_W-1:0]  rank_in;
   logic               xfer;

   assign xfer = rsp_tvalid && rsp_tready;

   // Load a new list or advance the queue by one slot per transfer
   always_comb begin
      slot_in   = slot_ff;
      remain_in = remain_ff;
      rank_in   = rank_ff;
      if (load_i) begin
         slot_in   = load_entries_i;
         remain_in = load_count_i;
         rank_in   = '0;
      end else if (xfer) begin
         for (int k = 0; k < MAX_KEEP - 1; k++) begin
            slot_in[k] = slot_ff[k + 1];
         end
         remain_in = remain_ff - CNT_W'(1);
         rank_in   = rank_ff + RANK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         rank_ff   <= '0;
      end else begin
         remain_ff <= remain_in;
         rank_ff   <= rank_in;
      end
      slot_ff <= slot_in;
   end

   assign busy_o      = (remain_ff != '0);
   assign rsp_tvalid  = (remain_ff != '0);
   assign rsp_tlast   = (remain_ff == CNT_W'(1));
   assign rsp_rank_o  = rank_ff;
   assign rsp_index_o = slot_ff[0].index;
   assign rsp_score_o = slot_ff[0].score;

   // A loaded non-empty list shows a result in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (load_i && load_count_i != '0) |=> rsp_tvalid)
      else $error("loaded list not presented");

   // The last transfer of a list leaves the buffer empty
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (xfer && rsp_tlast && !load_i) |=> !rsp_tvalid)
      else $error("result after end of list");

   // Ranks advance by one between transfers of the same list
   a_rank_step: assert property (@(posedge clock) disable iff (reset)
      (xfer && !rsp_tlast && !load_i) |=> (rsp_rank_o == $past(rsp_rank_o) + RANK_W'(1)))
      else $error("rank did not advance");

   // A list is never loaded over one still in flight
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load_i |-> !busy_o)
      else $error("list loaded while draining");

endmodule

/* rtl/core/top_n_index_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_index_select
// Streaming top-n selection: keeps the highest scores of a vector with their
// arrival indices and reports them best first at the end of the vector.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one signed Q16.16 score per transfer in req_tdata, req_tlast
//   on the last element of the vector. Elements are numbered from 0 in
//   arrival order. A row of MAX_KEEP cells keeps the list sorted; every cell
//   compares against the new score in the same cycle, so one element is
//   taken per cycle while req_tready is high.
//   rsp channel: after the last element, up to n_keep results follow, best
//   first (rank, index, score), rsp_tlast on the final one. The first result
//   is valid in the cycle after the last element's transfer, then one result
//   per cycle while rsp_tready is high.
//   The list moves into a result buffer on the last element, so elements of
//   the next vector are taken while results drain. The last element of the
//   next vector is held off (req_tready low) until the buffer is empty; a
//   receiver stall therefore stalls the input only at a vector end.
//   Equal scores rank the earlier element higher.
//   csr: csr_wr_en writes n_keep (0 acts as 1, above MAX_KEEP as MAX_KEEP).
//   Reset: list and result buffer empty, element count 0, n_keep 5.
// ----------------------------------------------------------------------------
module top_n_index_select
   import tnis_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [31:0] score
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   // rsp_tdata: [2:0] rank, [14:3] element_index, [46:15] element_score, pad
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [NKEEP_W-1:0]    csr_wr_data
);

   logic                      req_xfer;
   logic                      final_xfer;
   logic                      drain_busy;
   logic signed [SCORE_W-1:0] new_score;
   logic [INDEX_W-1:0]        elem_cnt_ff;
   logic [INDEX_W-1:0]        elem_cnt_in;
   logic [NKEEP_W-1:0]        n_keep_ff;
   logic [CNT_W-1:0]          limit;
   logic [CNT_W-1:0]          count;
   logic [RANK_W-1:0]         rsp_rank;
   logic [INDEX_W-1:0]        rsp_index;
   logic signed [SCORE_W-1:0] rsp_score;

   logic                      take     [MAX_KEEP];
   entry_type                 entry    [MAX_KEEP];
   entry_type                 entry_in [MAX_KEEP];

   assign new_score  = req_tdata[SCORE_W-1:0];
   // Hold off the last element while the previous list still drains
   assign req_tready = !(req_tlast && drain_busy);
   assign req_xfer   = req_tvalid && req_tready;
   assign final_xfer = req_xfer && req_tlast;

   // Count elements, wrap at the vector length, restart at a vector end
   always_comb begin
      elem_cnt_in = elem_cnt_ff;
      if (req_xfer) begin
         if (req_tlast || elem_cnt_ff == INDEX_W'(VECTOR_LEN - 1)) begin
            elem_cnt_in = '0;
         end else begin
            elem_cnt_in = elem_cnt_ff + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_cnt_ff <= '0;
         n_keep_ff   <= NKEEP_W'(5);
      end else begin
         elem_cnt_ff <= elem_cnt_in;
         if (csr_wr_en) begin
            n_keep_ff <= csr_wr_data;
         end
      end
   end

   // Row of sorting cells, best entry in cell 0
   for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
      logic      prev_take;
      entry_type prev_entry;
      if (g == 0) begin : g_head
         assign prev_take  = 1'b0;
         assign prev_entry = '0;
      end else begin : g_body
         assign prev_take  = take[g-1];
         assign prev_entry = entry[g-1];
      end
      tnis_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .insert_i     (req_xfer),
         .clear_i      (final_xfer),
         .new_score_i  (new_score),
         .new_index_i  (elem_cnt_ff),
         .prev_take_i  (prev_take),
         .prev_entry_i (prev_entry),
         .take_o       (take[g]),
         .entry_o      (entry[g]),
         .entry_in_o   (entry_in[g])
      );
   end

   // Clamp n_keep and count the valid entries within it
   always_comb begin
      if (n_keep_ff == '0) begin
         limit = CNT_W'(1);
      end else if (LIM_W'(n_keep_ff) > LIM_W'(MAX_KEEP)) begin
         limit = CNT_W'(MAX_KEEP);
      end else begin
         limit = CNT_W'(n_keep_ff);
      end
      count = '0;
      for (int k = 0; k < MAX_KEEP; k++) begin
         if (CNT_W'(k) < limit && entry_in[k].valid) begin
            count = count + CNT_W'(1);
         end
      end
   end

   tnis_drain u_drain (
      .clock          (clock),
      .reset          (reset),
      .load_i         (final_xfer),
      .load_entries_i (entry_in),
      .load_count_i   (count),
      .busy_o         (drain_busy),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_rank_o     (rsp_rank),
      .rsp_index_o    (rsp_index),
      .rsp_score_o    (rsp_score),
      .rsp_tlast      (rsp_tlast)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp_score, rsp_index, rsp_rank});

endmodule
